>>> sv/tbpd_pkg.sv
// ----------------------------------------------------------------------------
// Tile block pixel decoder package
// Shared constants, the decode phase type, the queue entry type and the
// fixed diamond tables of isometric blocks.
// ----------------------------------------------------------------------------
package tbpd_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_TEXTURE_WIDTH_DEF = 8192;
    localparam int TEXTURE_ROWS_DEF      = 4096;

    // Field widths fixed by the stream format.
    localparam int TW_W     = 14;
    localparam int ADDR_W   = 25;
    localparam int POS_W    = 17;
    localparam int BCOL_W   = 17;
    localparam int BROW_W   = 18;
    localparam int COORD_W  = 19;

    // Reset value of the texture width register.
    localparam logic [TW_W-1:0] TW_RESET = 14'd8192;

    // Tile kinds.
    localparam logic [1:0] KIND_FLOOR      = 2'd0;
    localparam logic [1:0] KIND_LOWER_WALL = 2'd1;

    localparam logic signed [BROW_W-1:0] LOWER_WALL_OFFSET = 18'sd96;

    // Number of rows in the isometric diamond.
    localparam logic [POS_W-1:0] ISO_ROWS = 17'd15;

    // Depth of the queue between the decoder and the address stage.
    localparam int FIFO_DEPTH = 4;

    // Run-length decode phase.
    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_COUNT = 2'd1,
        PH_PIXEL = 2'd2
    } phase_t;

    // One pixel waiting for its address: signed texture coordinates and byte.
    typedef struct packed {
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic [7:0]                pixel;
    } pix_t;

    // First column of each diamond row.
    function automatic logic [3:0] iso_start(input logic [3:0] r);
        logic [3:0] s;
        case (r)
            4'd0, 4'd14: s = 4'd14;
            4'd1, 4'd13: s = 4'd12;
            4'd2, 4'd12: s = 4'd10;
            4'd3, 4'd11: s = 4'd8;
            4'd4, 4'd10: s = 4'd6;
            4'd5, 4'd9:  s = 4'd4;
            4'd6, 4'd8:  s = 4'd2;
            default:     s = 4'd0;
        endcase
        return s;
    endfunction

    // Pixel count of each diamond row.
    function automatic logic [5:0] iso_count(input logic [3:0] r);
        logic [5:0] c;
        case (r)
            4'd0, 4'd14: c = 6'd4;
            4'd1, 4'd13: c = 6'd8;
            4'd2, 4'd12: c = 6'd12;
            4'd3, 4'd11: c = 6'd16;
            4'd4, 4'd10: c = 6'd20;
            4'd5, 4'd9:  c = 6'd24;
            4'd6, 4'd8:  c = 6'd28;
            4'd7:        c = 6'd32;
            default:     c = 6'd0;
        endcase
        return c;
    endfunction

endpackage

>>> sv/tbpd_front.sv
// ----------------------------------------------------------------------------
// Tile block pixel decoder front end
// Accepts one encoded byte per cycle while the queue has room, tracks the block
// decode state and pushes the coordinates of every pixel byte into the queue.
// ----------------------------------------------------------------------------
module tbpd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           data_byte,
    input  logic                                 block_start,
    input  logic                                 block_format,
    input  logic signed [15:0]                   block_x,
    input  logic signed [15:0]                   block_y,
    input  logic [12:0]                          rect_x,
    input  logic [11:0]                          rect_y,
    input  logic [1:0]                           tile_kind,
    input  logic signed [15:0]                   tile_height,
    input  logic                                 q_full,
    output logic                                 q_push,
    output tbpd_pkg::pix_t                       q_entry
);

    logic signed [tbpd_pkg::BCOL_W-1:0] base_col_reg, base_col_next;
    logic signed [tbpd_pkg::BROW_W-1:0] base_row_reg, base_row_next;
    logic [tbpd_pkg::POS_W-1:0]         cur_col_reg, cur_col_next;
    logic [tbpd_pkg::POS_W-1:0]         cur_row_reg, cur_row_next;
    logic                               iso_reg, iso_next;
    tbpd_pkg::phase_t                   phase_reg, phase_next;
    logic [7:0]                         skip_hold_reg, skip_hold_next;
    logic [7:0]                         pixels_left_reg, pixels_left_next;

    logic                               accept;
    logic                               emit;
    logic signed [tbpd_pkg::BROW_W-1:0] offset;
    logic signed [tbpd_pkg::BCOL_W-1:0] eff_base_col;
    logic signed [tbpd_pkg::BROW_W-1:0] eff_base_row;
    logic [tbpd_pkg::POS_W-1:0]         eff_col;
    logic [tbpd_pkg::POS_W-1:0]         eff_row;
    logic                               eff_iso;
    tbpd_pkg::phase_t                   eff_phase;
    logic [7:0]                         eff_skip;
    logic [7:0]                         eff_left;
    logic [7:0]                         left_dec;
    logic [tbpd_pkg::POS_W-1:0]         row_inc;

    assign accept   = in_valid && !q_full;
    assign in_ready = !q_full;

    // Row offset of the tile kind; unknown kinds behave as the generic kind.
    always_comb begin
        case (tile_kind)
            tbpd_pkg::KIND_FLOOR:      offset = '0;
            tbpd_pkg::KIND_LOWER_WALL: offset = tbpd_pkg::LOWER_WALL_OFFSET;
            default:                   offset = -{{2{tile_height[15]}}, tile_height};
        endcase
    end

    // State as seen by this byte: a block start reloads it first.
    always_comb begin
        if (block_start) begin
            eff_base_col = {block_x[15], block_x} + {4'b0, rect_x};
            eff_base_row = {{2{block_y[15]}}, block_y} + {6'b0, rect_y} + offset;
            eff_iso      = block_format;
            eff_phase    = tbpd_pkg::PH_SKIP;
            eff_skip     = '0;
            eff_row      = '0;
            if (block_format) begin
                eff_col  = tbpd_pkg::POS_W'(tbpd_pkg::iso_start(4'd0));
                eff_left = 8'(tbpd_pkg::iso_count(4'd0));
            end else begin
                eff_col  = '0;
                eff_left = '0;
            end
        end else begin
            eff_base_col = base_col_reg;
            eff_base_row = base_row_reg;
            eff_iso      = iso_reg;
            eff_phase    = phase_reg;
            eff_skip     = skip_hold_reg;
            eff_row      = cur_row_reg;
            eff_col      = cur_col_reg;
            eff_left     = pixels_left_reg;
        end
    end

    // Decode step for one byte.
    always_comb begin
        base_col_next    = eff_base_col;
        base_row_next    = eff_base_row;
        iso_next         = eff_iso;
        phase_next       = eff_phase;
        skip_hold_next   = eff_skip;
        cur_col_next     = eff_col;
        cur_row_next     = eff_row;
        pixels_left_next = eff_left;
        emit             = 1'b0;
        left_dec         = (eff_left != 8'd0) ? eff_left - 8'd1 : 8'd0;
        row_inc          = eff_row + 17'd1;

        if (eff_iso) begin
            // Isometric diamond: bytes after the last row are dropped.
            if (eff_row < tbpd_pkg::ISO_ROWS) begin
                emit             = 1'b1;
                cur_col_next     = eff_col + 17'd1;
                pixels_left_next = left_dec;
                if (left_dec == 8'd0) begin
                    cur_row_next = row_inc;
                    if (row_inc < tbpd_pkg::ISO_ROWS) begin
                        cur_col_next     = tbpd_pkg::POS_W'(tbpd_pkg::iso_start(row_inc[3:0]));
                        pixels_left_next = 8'(tbpd_pkg::iso_count(row_inc[3:0]));
                    end
                end
            end
        end else begin
            case (eff_phase)
                tbpd_pkg::PH_COUNT: begin
                    if (eff_skip == 8'd0 && data_byte == 8'd0) begin
                        // A zero pair ends the row.
                        cur_col_next = '0;
                        cur_row_next = row_inc;
                        phase_next   = tbpd_pkg::PH_SKIP;
                    end else begin
                        cur_col_next     = eff_col + {9'b0, eff_skip};
                        pixels_left_next = data_byte;
                        phase_next       = (data_byte != 8'd0) ? tbpd_pkg::PH_PIXEL
                                                               : tbpd_pkg::PH_SKIP;
                    end
                end
                tbpd_pkg::PH_PIXEL: begin
                    emit             = 1'b1;
                    cur_col_next     = eff_col + 17'd1;
                    pixels_left_next = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = tbpd_pkg::PH_SKIP;
                    end
                end
                default: begin
                    skip_hold_next = data_byte;
                    phase_next     = tbpd_pkg::PH_COUNT;
                end
            endcase
        end
    end

    // Pixel coordinates in the texture.
    assign q_entry.col   = {{2{eff_base_col[16]}}, eff_base_col} + {2'b0, eff_col};
    assign q_entry.row   = {eff_base_row[17], eff_base_row} + {2'b0, eff_row};
    assign q_entry.pixel = data_byte;
    assign q_push        = accept && emit;

    // Decode state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_col_reg    <= '0;
            base_row_reg    <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            iso_reg         <= 1'b0;
            phase_reg       <= tbpd_pkg::PH_SKIP;
            skip_hold_reg   <= '0;
            pixels_left_reg <= '0;
        end else if (accept) begin
            base_col_reg    <= base_col_next;
            base_row_reg    <= base_row_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            iso_reg         <= iso_next;
            phase_reg       <= phase_next;
            skip_hold_reg   <= skip_hold_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

endmodule

>>> sv/tbpd_fifo.sv
// ----------------------------------------------------------------------------
// Tile block pixel decoder queue
// Short first-in first-out queue of pixel entries between the decoder and
// the address stage.
// ----------------------------------------------------------------------------
module tbpd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tbpd_pkg::pix_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tbpd_pkg::pix_t pop_data
);

    localparam int DEPTH = tbpd_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbpd_pkg::pix_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/tbpd_back.sv
// ----------------------------------------------------------------------------
// Tile block pixel decoder address stage
// Holds the texture width register, checks pixel coordinates against the
// texture and forms the pixel address in two registered steps.
// ----------------------------------------------------------------------------
module tbpd_back #(
    parameter int MAX_TEXTURE_WIDTH = tbpd_pkg::MAX_TEXTURE_WIDTH_DEF,
    parameter int TEXTURE_ROWS      = tbpd_pkg::TEXTURE_ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [tbpd_pkg::TW_W-1:0]   cfg_wdata,
    input  logic                        q_valid,
    input  tbpd_pkg::pix_t              q_entry,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tbpd_pkg::ADDR_W-1:0] m_addr,
    output logic [7:0]                  m_index,
    output logic                        m_outside
);

    localparam int WW  = $clog2(MAX_TEXTURE_WIDTH + 1);
    localparam int RW  = $clog2(TEXTURE_ROWS);
    localparam int TWX = (WW > tbpd_pkg::TW_W) ? WW : tbpd_pkg::TW_W;
    localparam int PW  = RW + WW;
    localparam int SW  = PW + 1;

    logic [tbpd_pkg::TW_W-1:0]   tw_reg;
    logic                        a_valid_reg;
    logic [PW-1:0]               a_prod_reg;
    logic [WW-1:0]               a_col_reg;
    logic [7:0]                  a_pixel_reg;
    logic                        a_outside_reg;
    logic                        m_valid_reg;
    logic [tbpd_pkg::ADDR_W-1:0] m_addr_reg;
    logic [7:0]                  m_index_reg;
    logic                        m_outside_reg;

    logic [TWX-1:0]              tw_ext;
    logic [WW-1:0]               w_eff;
    logic                        col_out;
    logic                        row_out;
    logic [PW-1:0]               prod;
    logic [SW-1:0]               sum;
    logic                        out_load;
    logic                        a_load;

    // Texture width register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_reg <= tbpd_pkg::TW_RESET;
        end else if (cfg_we) begin
            tw_reg <= cfg_wdata;
        end
    end

    // Effective width: zero acts as one, the maximum caps larger values.
    always_comb begin
        tw_ext = TWX'(tw_reg);
        if (tw_reg == '0) begin
            w_eff = WW'(1);
        end else if (tw_ext > TWX'(MAX_TEXTURE_WIDTH)) begin
            w_eff = WW'(MAX_TEXTURE_WIDTH);
        end else begin
            w_eff = WW'(tw_ext);
        end
    end

    // Bounds check and row product of the entry at the head of the queue.
    assign col_out = q_entry.col[tbpd_pkg::COORD_W-1] ||
                     (q_entry.col[tbpd_pkg::COORD_W-2:0] >= (tbpd_pkg::COORD_W-1)'(w_eff));
    assign row_out = q_entry.row[tbpd_pkg::COORD_W-1] ||
                     (q_entry.row[tbpd_pkg::COORD_W-2:0] >= (tbpd_pkg::COORD_W-1)'(TEXTURE_ROWS));
    assign prod    = PW'(q_entry.row[RW-1:0]) * PW'(w_eff);

    // Handshake between the two stages and the result port.
    assign out_load = a_valid_reg && (!m_valid_reg || m_ready);
    assign a_load   = !a_valid_reg || out_load;
    assign q_pop    = q_valid && a_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_prod_reg    <= prod;
            a_col_reg     <= q_entry.col[WW-1:0];
            a_pixel_reg   <= q_entry.pixel;
            a_outside_reg <= col_out || row_out;
        end
    end

    // Final address: row product plus column, zero for outside pixels.
    assign sum = SW'(a_prod_reg) + SW'(a_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_addr_reg    <= a_outside_reg ? '0 : tbpd_pkg::ADDR_W'(sum);
            m_index_reg   <= a_pixel_reg;
            m_outside_reg <= a_outside_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_addr    = m_addr_reg;
    assign m_index   = m_index_reg;
    assign m_outside = m_outside_reg;

endmodule

>>> sv/tile_block_pixel_decoder_core.sv
// Accepts one encoded byte per cycle while the queue has room and delivers one
// pixel result per cycle while m_tready is high. A pixel byte is queued at its
// transfer; the address stage registers its row product, the result register its
// final add. Skip, count and tail bytes give no result; a stalled output fills
// the four-entry queue, then holds s_tready low. Synchronous active-low reset
// clears decode state, queue and result valid and sets the texture width to 8192.
// ----------------------------------------------------------------------------
// Tile block pixel decoder core
// Decodes run-length and isometric tile block bytes into texture pixel
// writes: address, palette index and an outside-texture flag.
// ----------------------------------------------------------------------------
module tile_block_pixel_decoder_core #(
    parameter int MAX_TEXTURE_WIDTH = tbpd_pkg::MAX_TEXTURE_WIDTH_DEF,
    parameter int TEXTURE_ROWS      = tbpd_pkg::TEXTURE_ROWS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Texture width register.
    input  logic                      cfg_we,
    input  logic [tbpd_pkg::TW_W-1:0] cfg_wdata,
    // Encoded byte stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // data_byte[7:0], block_x[23:8], block_y[39:24], rect_x[52:40],
    // rect_y[64:53], tile_height[80:65], zero[87:81]
    input  logic [87:0]               s_tdata,
    // block_start[0], block_format[1], tile_kind[3:2]
    input  logic [3:0]                s_tuser,
    // Pixel result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pixel_address[24:0], palette_index[32:25], zero[39:33]
    output logic [39:0]               m_tdata,
    // outside[0]
    output logic [0:0]                m_tuser
);

    logic                        q_full;
    logic                        q_push;
    tbpd_pkg::pix_t              q_in;
    logic                        q_pop;
    logic                        q_valid;
    tbpd_pkg::pix_t              q_out;
    logic [tbpd_pkg::ADDR_W-1:0] pixel_address;
    logic [7:0]                  palette_index;
    logic                        outside;

    // Byte decoder.
    tbpd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .data_byte    (s_tdata[7:0]),
        .block_start  (s_tuser[0]),
        .block_format (s_tuser[1]),
        .block_x      (s_tdata[23:8]),
        .block_y      (s_tdata[39:24]),
        .rect_x       (s_tdata[52:40]),
        .rect_y       (s_tdata[64:53]),
        .tile_kind    (s_tuser[3:2]),
        .tile_height  (s_tdata[80:65]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    // Pixel queue.
    tbpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    // Address stage and result register.
    tbpd_back #(
        .MAX_TEXTURE_WIDTH (MAX_TEXTURE_WIDTH),
        .TEXTURE_ROWS      (TEXTURE_ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_addr    (pixel_address),
        .m_index   (palette_index),
        .m_outside (outside)
    );

    // Result packing.
    assign m_tdata = {7'b0, palette_index, pixel_address};
    assign m_tuser = outside;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Tile block pixel decoder testbench
// Streams run-length and isometric tile blocks into the decoder under several
// texture widths and checks every pixel write against an in-bench decoder.
// A short table of directed bytes with hand-read writes comes first. Random
// blocks follow, with bursty idling on both sides outside the closing stretch.
// ----------------------------------------------------------------------------
module testbench;

    // Tile kinds beyond those named in the package.
    localparam logic [1:0] KIND_OTHER     = 2'd2;
    localparam logic [1:0] KIND_UNDEFINED = 2'd3;

    // Block formats.
    localparam bit FMT_RLE = 1'b0;
    localparam bit FMT_ISO = 1'b1;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 50;
    localparam int NUM_WIDTHS  = 6;

    // One encoded byte together with the block header fields.
    typedef struct packed {
        logic [7:0]         data;
        logic               start;
        logic               iso;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [12:0]        rx;
        logic [11:0]        ry;
        logic [1:0]         kind;
        logic signed [15:0] height;
    } enc_byte_t;

    // One texture write.
    typedef struct packed {
        logic [tbpd_pkg::ADDR_W-1:0] addr;
        logic [7:0]                  pixel;
        logic                        outside;
    } pixel_write_t;

    // A row of the directed table; a typed write replaces the predicted one.
    typedef struct packed {
        enc_byte_t    item;
        logic         has_write;
        pixel_write_t write;
    } directed_row_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [tbpd_pkg::TW_W-1:0] cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [87:0]   s_tdata;
    logic [3:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [39:0]   m_tdata;
    logic [0:0]    m_tuser;

    tile_block_pixel_decoder_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Decoder state kept by the bench.
    logic [tbpd_pkg::TW_W-1:0]  tex_width;
    int                         base_col_q;
    int                         base_row_q;
    logic [tbpd_pkg::POS_W-1:0] col_pos;
    logic [tbpd_pkg::POS_W-1:0] row_pos;
    logic                       iso_mode;
    tbpd_pkg::phase_t           dec_phase;
    logic [7:0]                 skip_q;
    logic [7:0]                 left_q;

    pixel_write_t     pending_writes[$];
    directed_row_t    directed_rows[$];

    // Side channel from the sender: typed write for the byte being offered.
    logic             offer_has_write;
    pixel_write_t     offer_write;

    bit               idle_on;
    int               errors;
    int               bytes_sent;
    int               writes_checked;
    int               cycles;
    enc_byte_t        hdr_item;
    bit               hdr_due;
    int               gen_width;

    // Width as the decoder uses it: zero acts as one, large values saturate.
    function automatic int clamp_width(input int w);
        if (w < 1)
            return 1;
        if (w > tbpd_pkg::MAX_TEXTURE_WIDTH_DEF)
            return tbpd_pkg::MAX_TEXTURE_WIDTH_DEF;
        return w;
    endfunction

    // Distance of a diamond row from the widest row in the middle.
    function automatic int diamond_dist(input int r);
        return (r < 7) ? 7 - r : r - 7;
    endfunction

    function automatic enc_byte_t mk_byte(input logic [7:0] data, input logic start,
                                          input logic iso, input logic [15:0] bx,
                                          input logic [15:0] by, input logic [12:0] rx,
                                          input logic [11:0] ry, input logic [1:0] kind,
                                          input logic [15:0] height);
        enc_byte_t it;
        it.data   = data;
        it.start  = start;
        it.iso    = iso;
        it.bx     = bx;
        it.by     = by;
        it.rx     = rx;
        it.ry     = ry;
        it.kind   = kind;
        it.height = height;
        return it;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input directed_row_t r);
        directed_rows = {directed_rows, r};
    endtask

    task automatic emit_pixel(input logic [7:0] b, output pixel_write_t px);
        longint c;
        longint r;
        longint w;
        c = col_pos;
        r = row_pos;
        c = c + base_col_q;
        r = r + base_row_q;
        w = clamp_width(tex_width);
        px.outside = (c < 0 || c >= w || r < 0 || r >= tbpd_pkg::TEXTURE_ROWS_DEF);
        px.addr    = px.outside ? '0 : tbpd_pkg::ADDR_W'(r * w + c);
        px.pixel   = b;
    endtask

    // Advances the decoder state by one byte; got is set when a pixel is written.
    task automatic decode_byte(input enc_byte_t it, output logic got,
                               output pixel_write_t px);
        int row_off;
        got = 1'b0;
        px  = '0;
        if (it.start) begin
            case (it.kind)
                tbpd_pkg::KIND_FLOOR:      row_off = 0;
                tbpd_pkg::KIND_LOWER_WALL: row_off = int'(tbpd_pkg::LOWER_WALL_OFFSET);
                default:                   row_off = -int'(it.height);
            endcase
            iso_mode   = it.iso;
            base_col_q = int'(it.bx) + int'(it.rx);
            base_row_q = int'(it.by) + int'(it.ry) + row_off;
            dec_phase  = tbpd_pkg::PH_SKIP;
            skip_q     = '0;
            row_pos    = '0;
            if (it.iso) begin
                col_pos = tbpd_pkg::POS_W'(2 * diamond_dist(0));
                left_q  = 8'(32 - 4 * diamond_dist(0));
            end else begin
                col_pos = '0;
                left_q  = '0;
            end
        end

        if (iso_mode) begin
            // Bytes past the last diamond row are dropped.
            if (row_pos < tbpd_pkg::ISO_ROWS) begin
                emit_pixel(it.data, px);
                got     = 1'b1;
                col_pos = col_pos + 1'b1;
                if (left_q != 0)
                    left_q = left_q - 1'b1;
                if (left_q == 0) begin
                    row_pos = row_pos + 1'b1;
                    if (row_pos < tbpd_pkg::ISO_ROWS) begin
                        col_pos = tbpd_pkg::POS_W'(2 * diamond_dist(int'(row_pos)));
                        left_q  = 8'(32 - 4 * diamond_dist(int'(row_pos)));
                    end
                end
            end
        end else begin
            case (dec_phase)
                tbpd_pkg::PH_COUNT: begin
                    if (skip_q == 0 && it.data == 0) begin
                        // A zero pair closes the row.
                        col_pos   = '0;
                        row_pos   = row_pos + 1'b1;
                        dec_phase = tbpd_pkg::PH_SKIP;
                    end else begin
                        col_pos   = col_pos + tbpd_pkg::POS_W'(skip_q);
                        left_q    = it.data;
                        dec_phase = (it.data != 0) ? tbpd_pkg::PH_PIXEL : tbpd_pkg::PH_SKIP;
                    end
                end
                tbpd_pkg::PH_PIXEL: begin
                    emit_pixel(it.data, px);
                    got     = 1'b1;
                    col_pos = col_pos + 1'b1;
                    if (left_q != 0)
                        left_q = left_q - 1'b1;
                    if (left_q == 0)
                        dec_phase = tbpd_pkg::PH_SKIP;
                end
                default: begin
                    skip_q    = it.data;
                    dec_phase = tbpd_pkg::PH_COUNT;
                end
            endcase
        end
    endtask

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tile_block_pixel_decoder_core: mismatch");
            $finish;
        end
    end

    // Result side: random stall bursts while idling is on.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Track register writes and byte transfers, and check every pixel transfer.
    always @(posedge aclk) begin : monitor
        enc_byte_t    it;
        pixel_write_t px;
        pixel_write_t want;
        logic         got;
        if (!aresetn) begin
            tex_width  = tbpd_pkg::TW_RESET;
            base_col_q = 0;
            base_row_q = 0;
            col_pos    = '0;
            row_pos    = '0;
            iso_mode   = 1'b0;
            dec_phase  = tbpd_pkg::PH_SKIP;
            skip_q     = '0;
            left_q     = '0;
        end else begin
            if (cfg_we)
                tex_width = cfg_wdata;

            if (s_tvalid && s_tready) begin
                it.data   = s_tdata[7:0];
                it.bx     = s_tdata[23:8];
                it.by     = s_tdata[39:24];
                it.rx     = s_tdata[52:40];
                it.ry     = s_tdata[64:53];
                it.height = s_tdata[80:65];
                it.start  = s_tuser[0];
                it.iso    = s_tuser[1];
                it.kind   = s_tuser[3:2];
                decode_byte(it, got, px);
                if (offer_has_write)
                    pending_writes = {pending_writes, offer_write};
                else if (got)
                    pending_writes = {pending_writes, px};
            end

            if (m_tvalid && m_tready) begin
                if (pending_writes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel write, expected none, actual %h %h %b",
                             $time, m_tdata[24:0], m_tdata[32:25], m_tuser[0]);
                end else begin
                    want = pending_writes.pop_front();
                    writes_checked++;
                    if (m_tdata[24:0] !== want.addr) begin
                        errors++;
                        $display("%0t: pixel_address expected %h actual %h",
                                 $time, want.addr, m_tdata[24:0]);
                    end
                    if (m_tdata[32:25] !== want.pixel) begin
                        errors++;
                        $display("%0t: palette_index expected %h actual %h",
                                 $time, want.pixel, m_tdata[32:25]);
                    end
                    if (m_tuser[0] !== want.outside) begin
                        errors++;
                        $display("%0t: outside expected %b actual %b",
                                 $time, want.outside, m_tuser[0]);
                    end
                end
            end
        end
    end

    // Offers one byte at a falling edge and returns at the falling edge after
    // its transfer.
    task automatic put_byte(input enc_byte_t it, input logic has_write,
                            input pixel_write_t write);
        if (idle_on && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid        <= 1'b1;
        s_tdata         <= {7'd0, it.height, it.ry, it.rx, it.by, it.bx, it.data};
        s_tuser         <= {it.kind, it.iso, it.start};
        offer_has_write = has_write;
        offer_write     = write;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Sends a data byte; the pending block header rides on the first one, and
    // the header fields of other bytes carry random values the block ignores.
    task automatic put_data(input logic [7:0] b);
        enc_byte_t it;
        if (hdr_due) begin
            it      = hdr_item;
            hdr_due = 1'b0;
        end else begin
            it = mk_byte(8'd0, 1'b0, 1'($urandom), 16'($urandom), 16'($urandom),
                         13'($urandom), 12'($urandom), 2'($urandom), 16'($urandom));
        end
        it.data = b;
        put_byte(it, 1'b0, '0);
    endtask

    // Random block header, mostly placed so that pixels land in the texture.
    function automatic enc_byte_t rand_header(input logic iso);
        enc_byte_t h;
        h = mk_byte(8'd0, 1'b1, iso, 16'($urandom), 16'($urandom), 13'($urandom),
                    12'($urandom), 2'($urandom_range(0, 3)), 16'($urandom));
        if ($urandom_range(0, 3) != 0) begin
            h.bx     = 16'($urandom_range(0, 40) - 20);
            h.by     = 16'($urandom_range(0, 40) - 20);
            h.rx     = 13'($urandom_range(0, gen_width - 1));
            h.ry     = 12'($urandom_range(0, 4000));
            h.height = 16'($urandom_range(0, 200) - 100);
        end
        return h;
    endfunction

    task automatic run_length_block();
        int skip;
        int cnt;
        hdr_item = rand_header(FMT_RLE);
        hdr_due  = 1'b1;
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 3)) begin
                skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 8);
                cnt  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 60)
                                                    : $urandom_range(0, 6);
                put_data(8'(skip));
                put_data(8'(cnt));
                repeat (cnt) put_data(8'($urandom_range(0, 255)));
                // Now and then the block is cut short by the next one.
                if ($urandom_range(0, 15) == 0)
                    return;
            end
            put_data(8'd0);
            put_data(8'd0);
        end
    endtask

    task automatic isometric_block(input enc_byte_t hdr, input int len);
        hdr_item = hdr;
        hdr_due  = 1'b1;
        repeat (len) put_data(8'($urandom_range(0, 255)));
    endtask

    // Stops offering and lets every expected write arrive, plus the latency
    // of any byte that gives no write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_width(input logic [tbpd_pkg::TW_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        gen_width = clamp_width(int'(w));
    endtask

    // Stimulus.
    initial begin : stimulus
        logic [tbpd_pkg::TW_W-1:0] widths [NUM_WIDTHS];
        int              goal;
        int              pick;
        int              len;
        enc_byte_t       hdr;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        offer_has_write = 1'b0;
        offer_write     = '0;
        idle_on         = 1'b1;
        errors          = 0;
        bytes_sent      = 0;
        writes_checked  = 0;
        cycles          = 0;
        hdr_due         = 1'b0;
        hdr_item        = '0;
        gen_width       = tbpd_pkg::MAX_TEXTURE_WIDTH_DEF;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Bytes before any block header decode as a run-length block at the
        // origin: a run of two, a zero count pair, a row end, a run of one.
        add_row('{mk_byte(8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h02, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'hFF, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'd0, 8'hFF, 1'b0}});
        add_row('{mk_byte(8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'd1, 8'h00, 1'b0}});
        add_row('{mk_byte(8'h03, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h00, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'hA5, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'd8193, 8'hA5, 1'b0}});
        // Field extremes, other kind: column far right of the texture.
        add_row('{mk_byte(8'h00, 1, FMT_RLE, 16'h7FFF, 16'h8000, 13'h1FFF,
                          12'hFFF, KIND_OTHER, 16'h8000), 0, '0});
        add_row('{mk_byte(8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h5A, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'd0, 8'h5A, 1'b1}});
        // Lower wall: the 96 row offset cancels the block row.
        add_row('{mk_byte(8'h00, 1, FMT_RLE, 16'd5, -16'sd96, 13'd10, 12'd0,
                          tbpd_pkg::KIND_LOWER_WALL, 16'h7FFF), 0, '0});
        add_row('{mk_byte(8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h3C, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'd15, 8'h3C, 1'b0}});
        // Undefined kind acts as other; last texel gives the top address.
        add_row('{mk_byte(8'h00, 1, FMT_RLE, 16'd0, 16'd0, 13'h1FFF, 12'd0,
                          KIND_UNDEFINED, -16'sd4095), 0, '0});
        add_row('{mk_byte(8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h81, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'h1FFFFFF, 8'h81, 1'b0}});
        // Negative column is outside and gives address zero.
        add_row('{mk_byte(8'h00, 1, FMT_RLE, 16'hFFFF, 16'd0, 13'd0, 12'd0,
                          tbpd_pkg::KIND_FLOOR, 16'd0), 0, '0});
        add_row('{mk_byte(8'h01, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        add_row('{mk_byte(8'h7E, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                  '{25'd0, 8'h7E, 1'b1}});
        // Isometric header byte is already the first diamond pixel.
        add_row('{mk_byte(8'h11, 1, FMT_ISO, 16'd0, 16'd0, 13'd0, 12'd0,
                          tbpd_pkg::KIND_FLOOR, 16'd0), 1,
                  '{25'd14, 8'h11, 1'b0}});

        foreach (directed_rows[i])
            put_byte(directed_rows[i].item, directed_rows[i].has_write,
                     directed_rows[i].write);
        drain();

        widths[0] = 14'd1;
        widths[1] = 14'd0;
        widths[2] = 14'h3FFF;
        widths[3] = 14'd8191;
        widths[4] = 14'($urandom_range(2, 200));
        widths[5] = 14'd8192;

        for (int p = 0; p < NUM_WIDTHS; p++) begin
            write_width(widths[p]);
            // The closing stretch runs without idling on either side.
            idle_on = (p != NUM_WIDTHS - 1);

            if (p == 3) begin
                // A whole diamond followed by tail bytes that give no write.
                isometric_block(mk_byte(8'd0, 1'b1, FMT_ISO, 0, 0, 13'd100, 12'd100,
                                        tbpd_pkg::KIND_FLOOR, 0), 256 + 3);
            end

            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    // Noise: random bytes with random header flags.
                    repeat ($urandom_range(1, 6))
                        put_byte(mk_byte(8'($urandom), $urandom_range(0, 3) == 0,
                                         1'($urandom), 16'($urandom), 16'($urandom),
                                         13'($urandom), 12'($urandom), 2'($urandom),
                                         16'($urandom)), 1'b0, '0);
                end else if (pick <= 3) begin
                    hdr = rand_header(FMT_ISO);
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 260)
                                                       : $urandom_range(1, 40);
                    isometric_block(hdr, len);
                end else begin
                    run_length_block();
                end
            end
            drain();
        end

        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d encoded bytes and checked %0d pixel writes", bytes_sent,
                 writes_checked);
        $display("over %0d texture width settings, both block formats and all tile kinds.",
                 NUM_WIDTHS + 1);
        if (errors == 0)
            $display("tile_block_pixel_decoder_core: match");
        else
            $display("tile_block_pixel_decoder_core: mismatch");
        $finish;
    end

endmodule
